### src/bms_pkg.sv
// Shared types, codes and reset constants of the balance mode supervisor.
package bms_pkg;

   // Operating modes as reported on the result channel.
   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_CALIB  = 3'd1,
      MODE_MANUAL = 3'd2,
      MODE_ASSIST = 3'd3,
      MODE_AUTO   = 3'd4,
      MODE_FALLEN = 3'd5,
      MODE_ESTOP  = 3'd6
   } mode_type;

   // Command codes of an input word.
   localparam logic [2:0] CMD_TICK        = 3'd0;
   localparam logic [2:0] CMD_REPLACE     = 3'd1;
   localparam logic [2:0] CMD_OR          = 3'd2;
   localparam logic [2:0] CMD_REF         = 3'd3;
   localparam logic [2:0] CMD_REF_TIMEOUT = 3'd4;

   // Request flag bit positions.
   localparam int FLAG_CALIB_MODE = 0;
   localparam int FLAG_MANUAL     = 1;
   localparam int FLAG_STOP       = 2;
   localparam int FLAG_RESUME     = 3;
   localparam int FLAG_TIMEOUT    = 4;
   localparam int FLAG_CAL_LO     = 5;
   localparam int FLAG_CAL_HI     = 8;
   localparam int FLAG_RETRACT    = 9;
   localparam int FLAG_DEPLOY     = 10;

   // Stand and steer motor actions.
   localparam logic [1:0] STAND_NONE    = 2'd0;
   localparam logic [1:0] STAND_DEPLOY  = 2'd1;
   localparam logic [1:0] STAND_RETRACT = 2'd2;

   localparam logic [1:0] MOTOR_NONE     = 2'd0;
   localparam logic [1:0] MOTOR_SHUTDOWN = 2'd1;
   localparam logic [1:0] MOTOR_POSITION = 2'd2;
   localparam logic [1:0] MOTOR_TORQUE   = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_FALL_ANGLE         = 3'd0;
   localparam logic [2:0] CSR_UPRIGHT_ANGLE      = 3'd1;
   localparam logic [2:0] CSR_OVERSTEER_ANGLE    = 3'd2;
   localparam logic [2:0] CSR_AUTO_ENTER_SPEED   = 3'd3;
   localparam logic [2:0] CSR_AUTO_LEAVE_SPEED   = 3'd4;
   localparam logic [2:0] CSR_ASSIST_ENTER_SPEED = 3'd5;
   localparam logic [2:0] CSR_ASSIST_LEAVE_SPEED = 3'd6;

   // Configuration reset values (angles Q4.12 rad, speeds Q8.8 m/s).
   localparam logic [14:0] RST_FALL_ANGLE         = 15'd1430;
   localparam logic [14:0] RST_UPRIGHT_ANGLE      = 15'd643;
   localparam logic [14:0] RST_OVERSTEER_ANGLE    = 15'd4289;
   localparam logic [14:0] RST_AUTO_ENTER_SPEED   = 15'd947;
   localparam logic [14:0] RST_AUTO_LEAVE_SPEED   = 15'd870;
   localparam logic [14:0] RST_ASSIST_ENTER_SPEED = 15'd154;
   localparam logic [14:0] RST_ASSIST_LEAVE_SPEED = 15'd128;

   typedef struct packed {
      logic [14:0] fall_angle;
      logic [14:0] upright_angle;
      logic [14:0] oversteer_angle;
      logic [14:0] auto_enter_speed;
      logic [14:0] auto_leave_speed;
      logic [14:0] assist_enter_speed;
      logic [14:0] assist_leave_speed;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [15:0] roll_angle;
      logic signed [15:0] steer_angle;
      logic signed [15:0] speed;
      logic [15:0]        elapsed_ms;
      logic [10:0]        request_bits;
      logic signed [15:0] reference_speed;
      logic [31:0]        timeout_ms;
   } req_type;

   typedef struct packed {
      mode_type           mode;
      logic [10:0]        flags;
      logic signed [15:0] speed_ref;
      logic [31:0]        time_counter;
      logic [31:0]        deadline;
      logic               free_flag;
      logic               brake;
   } state_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic               stand_free;
      logic               brake_engaged;
      logic [1:0]         stand_command;
      logic [1:0]         motor_command;
      logic               drive_stop;
      logic [3:0]         calib_requests;
      logic [10:0]        flags_now;
      logic signed [15:0] speed_reference_now;
   } rsp_type;

endpackage

### src/bms_csr.sv
// Configuration register file of the balance mode supervisor.
module bms_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [2:0]       csr_index,
   input  logic [14:0]      csr_write_data,
   output bms_pkg::cfg_type cfg
);

   bms_pkg::cfg_type cfg_ff;

   // Threshold registers, loaded one at a time by index.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fall_angle         <= bms_pkg::RST_FALL_ANGLE;
         cfg_ff.upright_angle      <= bms_pkg::RST_UPRIGHT_ANGLE;
         cfg_ff.oversteer_angle    <= bms_pkg::RST_OVERSTEER_ANGLE;
         cfg_ff.auto_enter_speed   <= bms_pkg::RST_AUTO_ENTER_SPEED;
         cfg_ff.auto_leave_speed   <= bms_pkg::RST_AUTO_LEAVE_SPEED;
         cfg_ff.assist_enter_speed <= bms_pkg::RST_ASSIST_ENTER_SPEED;
         cfg_ff.assist_leave_speed <= bms_pkg::RST_ASSIST_LEAVE_SPEED;
      end else if (csr_write_enable) begin
         case (csr_index)
            bms_pkg::CSR_FALL_ANGLE:         cfg_ff.fall_angle         <= csr_write_data;
            bms_pkg::CSR_UPRIGHT_ANGLE:      cfg_ff.upright_angle      <= csr_write_data;
            bms_pkg::CSR_OVERSTEER_ANGLE:    cfg_ff.oversteer_angle    <= csr_write_data;
            bms_pkg::CSR_AUTO_ENTER_SPEED:   cfg_ff.auto_enter_speed   <= csr_write_data;
            bms_pkg::CSR_AUTO_LEAVE_SPEED:   cfg_ff.auto_leave_speed   <= csr_write_data;
            bms_pkg::CSR_ASSIST_ENTER_SPEED: cfg_ff.assist_enter_speed <= csr_write_data;
            bms_pkg::CSR_ASSIST_LEAVE_SPEED: cfg_ff.assist_leave_speed <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/bms_step.sv
// Next-state and result logic for one word of the balance mode supervisor.
module bms_step (
   input  bms_pkg::cfg_type   cfg,
   input  bms_pkg::req_type   item,
   input  bms_pkg::state_type cur,
   output bms_pkg::state_type nxt,
   output bms_pkg::rsp_type   rsp
);

   logic signed [16:0] roll_x, steer_x, speed_x;
   logic [16:0]        roll_mag, steer_mag;
   logic               roll_fall, roll_upright, steer_over;
   logic               fast_assist, fast_auto, slow_auto, slow_assist;
   logic               ref_zero, ref_pos;
   logic [31:0]        tc_sum;
   logic [1:0]         stand;
   logic [1:0]         motor;
   logic               drv;
   logic [3:0]         calib;

   // Magnitudes and threshold compares; 17 bits hold the magnitude of -32768.
   always_comb begin
      roll_x       = 17'(item.roll_angle);
      steer_x      = 17'(item.steer_angle);
      speed_x      = 17'(item.speed);
      roll_mag     = roll_x[16] ? 17'(-roll_x) : 17'(roll_x);
      steer_mag    = steer_x[16] ? 17'(-steer_x) : 17'(steer_x);
      roll_fall    = roll_mag > {2'b00, cfg.fall_angle};
      roll_upright = roll_mag < {2'b00, cfg.upright_angle};
      steer_over   = steer_mag > {2'b00, cfg.oversteer_angle};
      fast_assist  = speed_x > $signed({2'b00, cfg.assist_enter_speed});
      fast_auto    = speed_x > $signed({2'b00, cfg.auto_enter_speed});
      slow_auto    = speed_x < $signed({2'b00, cfg.auto_leave_speed});
      slow_assist  = speed_x < $signed({2'b00, cfg.assist_leave_speed});
      ref_zero     = cur.speed_ref == 16'sd0;
      ref_pos      = !cur.speed_ref[15] && !ref_zero;
      tc_sum       = cur.time_counter + 32'(item.elapsed_ms);
   end

   // Transition checks run in order; every match applies its entry actions, a later one overriding an earlier.
   always_comb begin
      nxt   = cur;
      stand = bms_pkg::STAND_NONE;
      motor = bms_pkg::MOTOR_NONE;
      drv   = 1'b0;
      calib = 4'b0000;
      case (item.cmd)
         bms_pkg::CMD_TICK: begin
            nxt.time_counter = tc_sum;
            case (cur.mode)
               bms_pkg::MODE_IDLE: begin
                  if (roll_fall) begin
                     nxt.mode = bms_pkg::MODE_FALLEN; nxt.free_flag = 1'b0;
                     nxt.brake = 1'b1; drv = 1'b1; motor = bms_pkg::MOTOR_SHUTDOWN;
                  end
                  if (fast_assist || ref_pos) begin
                     nxt.mode = bms_pkg::MODE_ASSIST; nxt.free_flag = 1'b0;
                     stand = bms_pkg::STAND_DEPLOY; motor = bms_pkg::MOTOR_POSITION;
                  end
                  if (cur.flags[bms_pkg::FLAG_CALIB_MODE]) begin
                     nxt.mode = bms_pkg::MODE_CALIB; nxt.free_flag = 1'b0;
                  end
                  if (cur.flags[bms_pkg::FLAG_MANUAL]) begin
                     nxt.mode = bms_pkg::MODE_MANUAL; nxt.free_flag = 1'b0;
                  end
                  if (cur.flags[bms_pkg::FLAG_STOP]) begin
                     nxt.mode = bms_pkg::MODE_ESTOP; nxt.free_flag = 1'b0;
                     nxt.brake = 1'b1; stand = bms_pkg::STAND_DEPLOY;
                     drv = 1'b1; motor = bms_pkg::MOTOR_SHUTDOWN;
                  end
                  // Stand requests are served in idle; when both are pending, deploy wins and both are cleared.
                  if (cur.flags[bms_pkg::FLAG_RETRACT]) begin
                     stand = bms_pkg::STAND_RETRACT;
                     nxt.flags[bms_pkg::FLAG_RETRACT] = 1'b0;
                  end
                  if (cur.flags[bms_pkg::FLAG_DEPLOY]) begin
                     stand = bms_pkg::STAND_DEPLOY;
                     nxt.flags[bms_pkg::FLAG_DEPLOY] = 1'b0;
                  end
               end
               bms_pkg::MODE_CALIB: begin
                  if (cur.flags[bms_pkg::FLAG_RESUME]) begin
                     nxt.flags[bms_pkg::FLAG_CALIB_MODE] = 1'b0;
                     nxt.mode = bms_pkg::MODE_IDLE; nxt.free_flag = 1'b0;
                     nxt.brake = 1'b0; stand = bms_pkg::STAND_DEPLOY;
                     motor = bms_pkg::MOTOR_SHUTDOWN;
                  end
                  // Issue the pending calibration requests and clear them.
                  calib = cur.flags[bms_pkg::FLAG_CAL_HI:bms_pkg::FLAG_CAL_LO];
                  nxt.flags[bms_pkg::FLAG_CAL_HI:bms_pkg::FLAG_CAL_LO] = 4'b0000;
               end
               bms_pkg::MODE_MANUAL: begin
                  if (cur.flags[bms_pkg::FLAG_RESUME]) begin
                     nxt.flags[bms_pkg::FLAG_RESUME] = 1'b0;
                     nxt.flags[bms_pkg::FLAG_MANUAL] = 1'b0;
                     nxt.mode = bms_pkg::MODE_IDLE; nxt.free_flag = 1'b0;
                     nxt.brake = 1'b0; stand = bms_pkg::STAND_DEPLOY;
                     motor = bms_pkg::MOTOR_SHUTDOWN;
                  end
               end
               bms_pkg::MODE_ASSIST: begin
                  if (roll_fall) begin
                     nxt.mode = bms_pkg::MODE_FALLEN; nxt.free_flag = 1'b0;
                     nxt.brake = 1'b1; drv = 1'b1; motor = bms_pkg::MOTOR_SHUTDOWN;
                  end
                  if (fast_auto) begin
                     nxt.mode = bms_pkg::MODE_AUTO; nxt.free_flag = 1'b1;
                     motor = bms_pkg::MOTOR_TORQUE; stand = bms_pkg::STAND_RETRACT;
                  end
                  if (slow_assist && ref_zero) begin
                     nxt.mode = bms_pkg::MODE_IDLE; nxt.free_flag = 1'b0;
                     nxt.brake = 1'b0; stand = bms_pkg::STAND_DEPLOY;
                     motor = bms_pkg::MOTOR_SHUTDOWN;
                  end
                  if (cur.flags[bms_pkg::FLAG_STOP]) begin
                     nxt.mode = bms_pkg::MODE_ESTOP; nxt.free_flag = 1'b0;
                     nxt.brake = 1'b1; stand = bms_pkg::STAND_DEPLOY;
                     drv = 1'b1; motor = bms_pkg::MOTOR_SHUTDOWN;
                  end
                  // With no speed reference the brake holds the vehicle.
                  if (ref_zero) begin
                     nxt.brake = 1'b1;
                  end
               end
               bms_pkg::MODE_AUTO: begin
                  if (roll_fall) begin
                     nxt.mode = bms_pkg::MODE_FALLEN; nxt.free_flag = 1'b0;
                     nxt.brake = 1'b1; drv = 1'b1; motor = bms_pkg::MOTOR_SHUTDOWN;
                  end
                  if (slow_auto) begin
                     nxt.mode = bms_pkg::MODE_ASSIST; nxt.free_flag = 1'b0;
                     stand = bms_pkg::STAND_DEPLOY; motor = bms_pkg::MOTOR_POSITION;
                  end
                  if (cur.flags[bms_pkg::FLAG_STOP] || steer_over) begin
                     nxt.mode = bms_pkg::MODE_ESTOP; nxt.free_flag = 1'b0;
                     nxt.brake = 1'b1; stand = bms_pkg::STAND_DEPLOY;
                     drv = 1'b1; motor = bms_pkg::MOTOR_SHUTDOWN;
                  end
               end
               bms_pkg::MODE_FALLEN: begin
                  if (roll_upright) begin
                     nxt.mode = bms_pkg::MODE_IDLE; nxt.free_flag = 1'b0;
                     nxt.brake = 1'b0; stand = bms_pkg::STAND_DEPLOY;
                     motor = bms_pkg::MOTOR_SHUTDOWN;
                  end
               end
               bms_pkg::MODE_ESTOP: begin
                  if (roll_fall) begin
                     nxt.mode = bms_pkg::MODE_FALLEN; nxt.free_flag = 1'b0;
                     nxt.brake = 1'b1; drv = 1'b1; motor = bms_pkg::MOTOR_SHUTDOWN;
                  end
                  if (cur.flags[bms_pkg::FLAG_RESUME]) begin
                     nxt.flags[bms_pkg::FLAG_RESUME] = 1'b0;
                     nxt.flags[bms_pkg::FLAG_STOP] = 1'b0;
                     nxt.mode = bms_pkg::MODE_IDLE; nxt.free_flag = 1'b0;
                     nxt.brake = 1'b0; stand = bms_pkg::STAND_DEPLOY;
                     motor = bms_pkg::MOTOR_SHUTDOWN;
                  end
               end
               default: begin
               end
            endcase
            // An expired reference timeout drops the reference and stops the drive.
            if (nxt.flags[bms_pkg::FLAG_TIMEOUT] && (tc_sum > cur.deadline)) begin
               nxt.flags[bms_pkg::FLAG_TIMEOUT] = 1'b0;
               nxt.speed_ref = 16'sd0;
               drv = 1'b1;
            end
         end
         bms_pkg::CMD_REPLACE: begin
            nxt.flags = item.request_bits;
         end
         bms_pkg::CMD_OR: begin
            nxt.flags = cur.flags | item.request_bits;
         end
         bms_pkg::CMD_REF: begin
            nxt.speed_ref = item.reference_speed;
         end
         bms_pkg::CMD_REF_TIMEOUT: begin
            nxt.speed_ref = item.reference_speed;
            nxt.deadline = cur.time_counter + item.timeout_ms;
            nxt.flags[bms_pkg::FLAG_TIMEOUT] = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Result word reflects the state after this step.
   always_comb begin
      rsp.mode                = nxt.mode;
      rsp.stand_free          = nxt.free_flag;
      rsp.brake_engaged       = nxt.brake;
      rsp.stand_command       = stand;
      rsp.motor_command       = motor;
      rsp.drive_stop          = drv;
      rsp.calib_requests      = calib;
      rsp.flags_now           = nxt.flags;
      rsp.speed_reference_now = nxt.speed_ref;
   end

endmodule

### src/balance_mode_supervisor.sv
// Top level of the balance mode supervisor: input register, state, result register.
//
// Usage: every word on the req_ channel is either a control tick (cmd 0) carrying
// roll, steer, speed and elapsed milliseconds, or a command that rewrites the
// request flags or the speed reference. Each accepted word yields exactly one
// result word on the rsp_ channel with the mode, actuator commands, flags and
// speed reference after that step. Thresholds are written through the csr_
// port, which the user must do only while no word is in flight; the block has no guard.
// Path: a word held in the input register is processed by the single-pass mode
// logic when the result register is free or draining; the state and result
// registers load together and rsp_valid rises. Throughput: one word per cycle
// while rsp_ready stays high; the mode logic reads and writes the state
// registers in the same cycle, so back-to-back words chain without gaps.
// Reset: state returns to idle with flags, reference, timer and deadline
// cleared, thresholds take their reset values and both registers empty.
// Stall: while rsp_ready is low the result is held; the input register still
// takes one more word, after which req_ready drops until the result drains.
module balance_mode_supervisor (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic signed [15:0] req_roll_angle,
   input  logic signed [15:0] req_steer_angle,
   input  logic signed [15:0] req_speed,
   input  logic [15:0]        req_elapsed_ms,
   input  logic [10:0]        req_request_bits,
   input  logic signed [15:0] req_reference_speed,
   input  logic [31:0]        req_timeout_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_mode,
   output logic               rsp_stand_free,
   output logic               rsp_brake_engaged,
   output logic [1:0]         rsp_stand_command,
   output logic [1:0]         rsp_motor_command,
   output logic               rsp_drive_stop,
   output logic [3:0]         rsp_calib_requests,
   output logic [10:0]        rsp_flags_now,
   output logic signed [15:0] rsp_speed_reference_now,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [14:0]        csr_write_data
);

   bms_pkg::cfg_type   cfg;
   bms_pkg::req_type   item_ff, item_in;
   logic               in_valid_ff;
   bms_pkg::state_type state_ff, state_in;
   bms_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff;
   logic               advance;

   bms_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bms_step u_step (
      .cfg  (cfg),
      .item (item_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .rsp  (rsp_in)
   );

   // The held word is processed when the result register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      item_in.cmd             = req_cmd;
      item_in.roll_angle      = req_roll_angle;
      item_in.steer_angle     = req_steer_angle;
      item_in.speed           = req_speed;
      item_in.elapsed_ms      = req_elapsed_ms;
      item_in.request_bits    = req_request_bits;
      item_in.reference_speed = req_reference_speed;
      item_in.timeout_ms      = req_timeout_ms;
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Valid flags and supervisor state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         state_ff.mode         <= bms_pkg::MODE_IDLE;
         state_ff.flags        <= '0;
         state_ff.speed_ref    <= '0;
         state_ff.time_counter <= '0;
         state_ff.deadline     <= '0;
         state_ff.free_flag    <= 1'b0;
         state_ff.brake        <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_mode                = rsp_ff.mode;
   assign rsp_stand_free          = rsp_ff.stand_free;
   assign rsp_brake_engaged       = rsp_ff.brake_engaged;
   assign rsp_stand_command       = rsp_ff.stand_command;
   assign rsp_motor_command       = rsp_ff.motor_command;
   assign rsp_drive_stop          = rsp_ff.drive_stop;
   assign rsp_calib_requests      = rsp_ff.calib_requests;
   assign rsp_flags_now           = rsp_ff.flags_now;
   assign rsp_speed_reference_now = rsp_ff.speed_reference_now;

endmodule

### src/bms_checker.sv
// Port-level checker of the balance mode supervisor and its bind.
module bms_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_mode,
   input logic               rsp_stand_free,
   input logic               rsp_brake_engaged,
   input logic [3:0]         rsp_calib_requests,
   input logic [10:0]        rsp_flags_now,
   input logic signed [15:0] rsp_speed_reference_now
);

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result word holds its mode, flags and speed reference.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode)
         && $stable(rsp_flags_now) && $stable(rsp_speed_reference_now))
      else $error("stalled result word changed");

   // The stand is held retracted only in automatic mode.
   a_free_auto: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stand_free |-> rsp_mode == bms_pkg::MODE_AUTO)
      else $error("stand released outside automatic mode");

   // Fallen and emergency stop always keep the brake engaged.
   a_brake_safe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode == bms_pkg::MODE_FALLEN || rsp_mode == bms_pkg::MODE_ESTOP)
         |-> rsp_brake_engaged)
      else $error("brake released in fallen or emergency stop");

   // Calibration requests are issued only from calibrate, which can only leave to idle.
   a_calib_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calib_requests != 4'b0000
         |-> rsp_mode == bms_pkg::MODE_CALIB || rsp_mode == bms_pkg::MODE_IDLE)
      else $error("calibration request outside calibrate mode");

endmodule

bind balance_mode_supervisor bms_checker u_bms_checker (.*);
